/* sv/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// A condition that must hold at every clock edge out of reset.
`define CHK_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("srpt scheduler check failed");
// A consequence that must hold in the same cycle.
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srpt scheduler check failed");
// A consequence that must hold in the following cycle.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srpt scheduler check failed");
`else
`define CHK_ALWAYS(lbl, expr)
`define CHK_SAME(lbl, ante, cons)
`define CHK_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/srpt_pkg.sv */
// Shared types, widths and codes for the shortest-remaining-time scheduler.
`timescale 1ns / 1ps
`default_nettype none
package srpt_pkg;

  localparam int MAX_JOBS_DEF = 16;
  localparam int ID_W         = 16;
  localparam int TIME_W       = 32;

  // Request kinds.
  localparam logic REQ_ARRIVE   = 1'b0;
  localparam logic REQ_COMPLETE = 1'b1;

  // Operations of the shared arithmetic unit.
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] job_length;
    logic [TIME_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic              done_valid;
    logic [ID_W-1:0]   done_id;
    logic              cancel_prior;
    logic              sched_valid;
    logic [TIME_W-1:0] sched_time;
    logic              running_valid;
    logic [ID_W-1:0]   running_id;
    logic              table_full;
  } rsp_t;

  // Write and clear commands from the sequencer to the job table.
  typedef struct packed {
    logic              wr_en;
    logic              clr_en;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] rem;
  } tbl_ctl_t;

endpackage
`default_nettype wire

/* sv/srpt_alu.sv */
// Shared 32-bit add/subtract unit with borrow out, used for every time computation.
`timescale 1ns / 1ps
`default_nettype none
module srpt_alu import srpt_pkg::*; (
  input  logic              op,
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  output logic [TIME_W-1:0] res,
  output logic              borrow
);

  logic [TIME_W:0] wide;

  // One extra bit carries the borrow of a subtraction.
  always_comb begin
    unique case (op)
      ALU_ADD: wide = {1'b0, a} + {1'b0, b};
      ALU_SUB: wide = {1'b0, a} - {1'b0, b};
      default: wide = '0;
    endcase
  end

  assign res    = wide[TIME_W-1:0];
  assign borrow = wide[TIME_W] & (op == ALU_SUB);

endmodule
`default_nettype wire

/* sv/srpt_table.sv */
// Job table: id and remaining-time memories plus per-slot valid flags.
`timescale 1ns / 1ps
`default_nettype none
module srpt_table import srpt_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF,
  localparam int SLOT_W  = $clog2(MAX_JOBS)
) (
  input  logic              clk,
  input  logic              rst,
  input  tbl_ctl_t          ctl,
  input  logic [SLOT_W-1:0] ctl_slot,
  input  logic [SLOT_W-1:0] rd_slot,
  output logic [ID_W-1:0]   rd_id,
  output logic [TIME_W-1:0] rd_rem,
  output logic              rd_vld,
  output logic [MAX_JOBS-1:0] valid_bits
);

  logic [ID_W-1:0]   id_mem  [MAX_JOBS];
  logic [TIME_W-1:0] rem_mem [MAX_JOBS];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      id_mem[ctl_slot]  <= ctl.id;
      rem_mem[ctl_slot] <= ctl.rem;
    end
    rd_id  <= id_mem[rd_slot];
    rd_rem <= rem_mem[rd_slot];
  end

  // Valid flags live in flip-flops so reset empties the table at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_vld     <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_bits[ctl_slot] <= 1'b1;
      end
      if (ctl.clr_en) begin
        valid_bits[ctl_slot] <= 1'b0;
      end
      rd_vld <= valid_bits[rd_slot];
    end
  end

endmodule
`default_nettype wire

/* sv/srpt_job_scheduler.sv */
// Top level of the preemptive shortest-remaining-time job scheduler.
// Usage:
//   A request on req_data is either a job arrival (id, length, time) or a
//   completion event for the running job. It is taken at a clock edge with
//   req_valid high and req_stall low. Each request yields exactly one response
//   on rsp_data, presented with rsp_valid and taken when rsp_stall is low.
// Sequence (from the cycle in which the request is taken up to the edge
// that loads the output register; the next request is taken right after):
//   Requests are handled one at a time. A full-table arrival or a completion
//   on an empty table goes straight to the output state. The first job passes
//   through ST_A_FIRST, a completion that empties the table through ST_C_START.
//   Other arrivals search the valid flags for the lowest free slot, one slot
//   per cycle, then use the shared adder three or four times. A completion
//   that leaves jobs behind scans the job table through its single read port,
//   one entry per cycle.
// Reset (rst, synchronous) empties the table and clears all control state.
// A response that is stalled stays in the output register; the next request
// is accepted meanwhile, and its response waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module srpt_job_scheduler import srpt_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  localparam int SLOT_W = $clog2(MAX_JOBS);
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_JOBS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_JOBS);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_A_FIRST  = 4'd1;
  localparam logic [3:0] ST_A_FREE   = 4'd2;
  localparam logic [3:0] ST_A_ELAP   = 4'd3;
  localparam logic [3:0] ST_A_CHARGE = 4'd4;
  localparam logic [3:0] ST_A_CMP    = 4'd5;
  localparam logic [3:0] ST_A_SCHED  = 4'd6;
  localparam logic [3:0] ST_C_START  = 4'd7;
  localparam logic [3:0] ST_C_SCAN   = 4'd8;
  localparam logic [3:0] ST_C_LAST   = 4'd9;
  localparam logic [3:0] ST_C_SCHED  = 4'd10;
  localparam logic [3:0] ST_PUSH     = 4'd11;

  logic [3:0]        state;
  req_t              cur;
  rsp_t              res;
  rsp_t              full_rsp;
  logic [CNT_W-1:0]  job_count;
  logic [SLOT_W-1:0] running_slot;
  logic [TIME_W-1:0] start_time;
  logic [ID_W-1:0]   run_id;
  logic [TIME_W-1:0] run_rem;
  logic [TIME_W-1:0] elapsed;
  logic [SLOT_W-1:0] idx;
  logic              pend;
  logic [SLOT_W-1:0] pend_slot;
  logic              found;
  logic [SLOT_W-1:0] best_slot;
  logic [TIME_W-1:0] best_rem;
  logic [ID_W-1:0]   best_id;

  logic              alu_op;
  logic [TIME_W-1:0] alu_a;
  logic [TIME_W-1:0] alu_b;
  logic [TIME_W-1:0] alu_res;
  logic              alu_borrow;
  logic [TIME_W-1:0] charged;
  logic              take;

  tbl_ctl_t          ctl;
  logic [SLOT_W-1:0] ctl_slot;
  logic [ID_W-1:0]   rd_id;
  logic [TIME_W-1:0] rd_rem;
  logic              rd_vld;
  logic [MAX_JOBS-1:0] valid_bits;

  assign req_stall = (state != ST_IDLE);

  // Operand selection for the shared add/subtract unit.
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = cur.now_time;
    alu_b  = start_time;
    unique case (state) inside
      ST_A_FIRST, ST_A_SCHED: begin
        alu_op = ALU_ADD;
        alu_a  = cur.now_time;
        alu_b  = cur.job_length;
      end
      ST_A_CHARGE: begin
        alu_a = run_rem;
        alu_b = elapsed;
      end
      ST_A_CMP: begin
        alu_a = cur.job_length;
        alu_b = run_rem;
      end
      ST_C_SCAN, ST_C_LAST: begin
        alu_a = rd_rem;
        alu_b = best_rem;
      end
      ST_C_SCHED: begin
        alu_op = ALU_ADD;
        alu_a  = cur.now_time;
        alu_b  = best_rem;
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  srpt_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  // Charged remaining time saturates at zero.
  assign charged = alu_borrow ? '0 : alu_res;

  // A scanned entry wins on smaller remaining time, then on smaller id.
  assign take = pend && rd_vld &&
                (!found || alu_borrow || ((alu_res == '0) && (rd_id < best_id)));

  // Response for an arrival that finds the table full.
  always_comb begin
    full_rsp               = '0;
    full_rsp.table_full    = 1'b1;
    full_rsp.running_valid = 1'b1;
    full_rsp.running_id    = run_id;
  end

  // Table writes and clears issued by the sequencer.
  always_comb begin
    ctl      = '0;
    ctl_slot = running_slot;
    unique case (state)
      ST_A_FIRST: begin
        ctl.wr_en = 1'b1;
        ctl.id    = cur.job_id;
        ctl.rem   = cur.job_length;
        ctl_slot  = '0;
      end
      ST_A_CHARGE: begin
        ctl.wr_en = 1'b1;
        ctl.id    = run_id;
        ctl.rem   = charged;
      end
      ST_A_CMP: begin
        ctl.wr_en = 1'b1;
        ctl.id    = cur.job_id;
        ctl.rem   = cur.job_length;
        ctl_slot  = idx;
      end
      ST_C_START: begin
        ctl.clr_en = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  srpt_table #(.MAX_JOBS(MAX_JOBS)) u_table (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .ctl_slot   (ctl_slot),
    .rd_slot    (idx),
    .rd_id      (rd_id),
    .rd_rem     (rd_rem),
    .rd_vld     (rd_vld),
    .valid_bits (valid_bits)
  );

  // Response valid: set when a response is loaded, cleared once it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_PUSH) && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Sequencer and scheduler state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      job_count    <= '0;
      running_slot <= '0;
      start_time   <= '0;
      pend         <= 1'b0;
      found        <= 1'b0;
      idx          <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur <= req_data;
            idx <= '0;
            if ((req_data.req_type == REQ_ARRIVE) && (job_count == FULL_CNT)) begin
              res <= full_rsp;
            end else begin
              res <= '0;
            end
            if (req_data.req_type == REQ_ARRIVE) begin
              if (job_count == '0) begin
                state <= ST_A_FIRST;
              end else if (job_count == FULL_CNT) begin
                state <= ST_PUSH;
              end else begin
                state <= ST_A_FREE;
              end
            end else if (job_count == '0) begin
              state <= ST_PUSH;
            end else begin
              state <= ST_C_START;
            end
          end
        end
        ST_A_FIRST: begin
          job_count         <= CNT_W'(1);
          running_slot      <= '0;
          start_time        <= cur.now_time;
          run_rem           <= cur.job_length;
          run_id            <= cur.job_id;
          res.sched_valid   <= 1'b1;
          res.sched_time    <= alu_res;
          res.running_valid <= 1'b1;
          res.running_id    <= cur.job_id;
          state             <= ST_PUSH;
        end
        ST_A_FREE: begin
          if (!valid_bits[idx]) begin
            state <= ST_A_ELAP;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_A_ELAP: begin
          elapsed <= alu_res;
          state   <= ST_A_CHARGE;
        end
        ST_A_CHARGE: begin
          run_rem    <= charged;
          start_time <= cur.now_time;
          state      <= ST_A_CMP;
        end
        ST_A_CMP: begin
          job_count         <= job_count + 1'b1;
          res.running_valid <= 1'b1;
          if (alu_borrow) begin
            running_slot     <= idx;
            run_rem          <= cur.job_length;
            run_id           <= cur.job_id;
            res.cancel_prior <= 1'b1;
            res.running_id   <= cur.job_id;
            state            <= ST_A_SCHED;
          end else begin
            res.running_id <= run_id;
            state          <= ST_PUSH;
          end
        end
        ST_A_SCHED: begin
          res.sched_valid <= 1'b1;
          res.sched_time  <= alu_res;
          state           <= ST_PUSH;
        end
        ST_C_START: begin
          res.done_valid <= 1'b1;
          res.done_id    <= run_id;
          job_count      <= job_count - 1'b1;
          idx            <= '0;
          found          <= 1'b0;
          pend           <= 1'b0;
          if (job_count == CNT_W'(1)) begin
            state <= ST_PUSH;
          end else begin
            state <= ST_C_SCAN;
          end
        end
        ST_C_SCAN: begin
          pend      <= 1'b1;
          pend_slot <= idx;
          if (take) begin
            found     <= 1'b1;
            best_slot <= pend_slot;
            best_rem  <= rd_rem;
            best_id   <= rd_id;
          end
          if (idx == LAST_SLOT) begin
            state <= ST_C_LAST;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_C_LAST: begin
          pend <= 1'b0;
          if (take) begin
            found     <= 1'b1;
            best_slot <= pend_slot;
            best_rem  <= rd_rem;
            best_id   <= rd_id;
          end
          state <= ST_C_SCHED;
        end
        ST_C_SCHED: begin
          running_slot      <= best_slot;
          start_time        <= cur.now_time;
          run_rem           <= best_rem;
          run_id            <= best_id;
          res.sched_valid   <= 1'b1;
          res.sched_time    <= alu_res;
          res.running_valid <= 1'b1;
          res.running_id    <= best_id;
          state             <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_data <= res;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Consistency checks on the job count, the table, the request handshake and the response.
  `CHK_ALWAYS(a_count_bound, job_count <= FULL_CNT)
  `CHK_SAME(a_count_flags, state == ST_IDLE, $countones(valid_bits) == int'(job_count))
  `CHK_NEXT(a_busy_after_req, req_valid && !req_stall, state != ST_IDLE)
  `CHK_SAME(a_sched_runs, rsp_valid && rsp_data.sched_valid, rsp_data.running_valid)

endmodule
`default_nettype wire

/* sim/srpt_checker.sv */
// Checker for the job scheduler: predicts each response and compares it with the one taken.
`timescale 1ns / 1ps
module srpt_checker import srpt_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req_data,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp_data,
  output int   errors,
  output int   pending
);

  // Shadow copy of the job table and the running-job bookkeeping.
  logic [ID_W-1:0]   slot_id   [MAX_JOBS];
  logic [TIME_W-1:0] slot_rem  [MAX_JOBS];
  logic              slot_used [MAX_JOBS];
  int                run_slot;
  logic [TIME_W-1:0] run_start;
  int                job_total;

  // Responses predicted for accepted requests, oldest first.
  rsp_t expected_rsps[$];
  int   rsp_index;

  // Print one line per mismatch and count every one.
  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns: response %0d: %s", $time, rsp_index, msg);
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                             input logic [TIME_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    end
  endtask

  // Apply one request to the shadow table and return the response it should cause.
  function automatic rsp_t predict_schedule(input req_t r);
    rsp_t              o;
    int                s;
    int                pick;
    logic [TIME_W-1:0] left;
    logic [TIME_W-1:0] gone;
    o = '0;
    left = '0;
    if (r.req_type == REQ_ARRIVE) begin
      if (job_total >= MAX_JOBS) begin
        // Full table: the arrival is dropped and nothing is charged.
        o.table_full = 1'b1;
      end else begin
        // Charge the running job for the time since it started, saturating at zero.
        if (job_total != 0) begin
          gone = r.now_time - run_start;
          left = (gone > slot_rem[run_slot]) ? '0 : slot_rem[run_slot] - gone;
          slot_rem[run_slot] = left;
        end
        // The new job takes the lowest free slot.
        s = 0;
        while (slot_used[s]) s++;
        slot_id[s]   = r.job_id;
        slot_rem[s]  = r.job_length;
        slot_used[s] = 1'b1;
        // A first job always runs; a later one only if strictly shorter.
        if (job_total == 0 || left > r.job_length) begin
          o.cancel_prior = (job_total != 0);
          run_slot       = s;
          o.sched_valid  = 1'b1;
          o.sched_time   = r.now_time + r.job_length;
        end
        run_start = r.now_time;
        job_total++;
      end
      o.running_valid = 1'b1;
      o.running_id    = slot_id[run_slot];
    end else if (job_total != 0) begin
      // Completion: retire the running job and start the shortest one left.
      o.done_valid          = 1'b1;
      o.done_id             = slot_id[run_slot];
      slot_used[run_slot]   = 1'b0;
      job_total--;
      if (job_total != 0) begin
        pick = -1;
        for (s = 0; s < MAX_JOBS; s++) begin
          if (slot_used[s] && (pick < 0 || slot_rem[s] < slot_rem[pick] ||
              (slot_rem[s] == slot_rem[pick] && slot_id[s] < slot_id[pick]))) begin
            pick = s;
          end
        end
        run_slot        = pick;
        run_start       = r.now_time;
        o.sched_valid   = 1'b1;
        o.sched_time    = r.now_time + slot_rem[pick];
        o.running_valid = 1'b1;
        o.running_id    = slot_id[pick];
      end
    end
    return o;
  endfunction

  // Watch both channels: predict on each request, compare on each response.
  always @(posedge clk) begin : watch
    rsp_t want;
    int   i;
    if (rst) begin
      for (i = 0; i < MAX_JOBS; i++) begin
        slot_used[i] = 1'b0;
        slot_id[i]   = '0;
        slot_rem[i]  = '0;
      end
      run_slot  = 0;
      run_start = '0;
      job_total = 0;
      expected_rsps.delete();
      rsp_index = 0;
      errors    = 0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(predict_schedule(req_data));
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("response with no request waiting");
        end else begin
          want = expected_rsps.pop_front();
          check_field("done_valid", TIME_W'(rsp_data.done_valid),
                      TIME_W'(want.done_valid));
          check_field("done_id", TIME_W'(rsp_data.done_id), TIME_W'(want.done_id));
          check_field("cancel_prior", TIME_W'(rsp_data.cancel_prior),
                      TIME_W'(want.cancel_prior));
          check_field("sched_valid", TIME_W'(rsp_data.sched_valid),
                      TIME_W'(want.sched_valid));
          check_field("sched_time", rsp_data.sched_time, want.sched_time);
          check_field("running_valid", TIME_W'(rsp_data.running_valid),
                      TIME_W'(want.running_valid));
          check_field("running_id", TIME_W'(rsp_data.running_id),
                      TIME_W'(want.running_id));
          check_field("table_full", TIME_W'(rsp_data.table_full),
                      TIME_W'(want.table_full));
        end
        rsp_index++;
      end
    end
    pending = expected_rsps.size();
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for the job scheduler: clock, reset, request and stall stimulus, verdict.
`timescale 1ns / 1ps
module tb_top;
  import srpt_pkg::*;

  localparam int RANDOM_REQS    = 1800;
  localparam int PHASE_LEN      = 450;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req_data;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp_data;

  int fail_count;
  int pending;

  // Idle rates in percent, and requests for a long receiver hold-off.
  int send_idle_pct;
  int stall_pct;
  int hold_asks;
  int quiet_cycles;

  // Simulated time carried by the requests; it wraps modulo 2^32.
  logic [TIME_W-1:0] sim_now;

  srpt_job_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  srpt_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .errors    (fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one request after a random idle gap and hold it until it is taken.
  task automatic send(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic arrive(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] len,
                        input logic [TIME_W-1:0] advance);
    req_t r;
    sim_now      = sim_now + advance;
    r.req_type   = REQ_ARRIVE;
    r.job_id     = id;
    r.job_length = len;
    r.now_time   = sim_now;
    send(r);
  endtask

  // Completion request; the id and length fields carry random noise.
  task automatic complete(input logic [TIME_W-1:0] advance);
    req_t r;
    sim_now      = sim_now + advance;
    r.req_type   = REQ_COMPLETE;
    r.job_id     = ID_W'($urandom());
    r.job_length = $urandom();
    r.now_time   = sim_now;
    send(r);
  endtask

  // Stop offering requests until every predicted response has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin : receiver
    int holds_served;
    holds_served = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_served) begin
        holds_served++;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Request stimulus: directed cases first, then random phases.
  initial begin : sender
    int                n;
    int                k;
    int                arrive_pct;
    int                roll;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] len;
    logic [TIME_W-1:0] advance;
    rst           = 1'b1;
    req_valid     = 1'b0;
    req_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_asks     = 0;
    sim_now       = '0;
    arrive_pct    = 50;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Completion on an empty table, then the longest job with the top id.
    complete(0);
    arrive(16'hFFFF, 32'hFFFF_FFFF, 0);
    // Equal remaining time does not preempt; a zero-length job does.
    arrive(16'h1234, 32'hFFFF_FFFF, 0);
    arrive(16'h0000, 32'h0000_0000, 7);
    // Completion picks the shortest remaining job; its finish time lands on 32'hFFFF_FFFF, just short of the wrap.
    complete(0);
    arrive(16'h0005, 32'd100, 3);
    // Fill the table with equal lengths and falling ids, then overflow it.
    for (k = 0; k < 13; k++) begin
      arrive(16'h00F0 - k[ID_W-1:0], 32'd50, 1);
    end
    arrive(16'h5555, 32'd1, 1);
    // Jump close to the wrap point, then past it so the running job saturates.
    complete(32'hFFFF_FFF0 - sim_now);
    arrive(16'hAAAA, 32'd1, 32'h0000_0110);
    complete(0);
    arrive(16'h8000, 32'h8000_0000, 5);

    // Random part in four idling phases; each starts from a drained block.
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % PHASE_LEN == 0) begin
        wait_drained();
        case (n / PHASE_LEN)
          0: begin
            send_idle_pct = 0;
            stall_pct     = 0;
            // Receiver holds off while requests keep coming, so the block backs up.
            hold_asks <= hold_asks + 1;
          end
          1: begin
            send_idle_pct = 85;
            stall_pct     = 0;
          end
          2: begin
            send_idle_pct = 0;
            stall_pct     = 85;
          end
          default: begin
            send_idle_pct = 35;
            stall_pct     = 35;
          end
        endcase
      end
      // Vary the arrival share so the table both fills up and empties out.
      if (n % 60 == 0) begin
        case ($urandom_range(3))
          0: arrive_pct = 25;
          1: arrive_pct = 50;
          2: arrive_pct = 75;
          default: arrive_pct = 95;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 60) advance = $urandom_range(20);
      else if (roll < 85) advance = $urandom_range(300);
      else if (roll < 97) advance = $urandom_range(65535);
      else advance = $urandom();
      roll = $urandom_range(99);
      if (roll < 45) len = $urandom_range(64, 1);
      else if (roll < 65) len = $urandom_range(5000, 1);
      else if (roll < 80) len = 10 * (1 + $urandom_range(2));
      else if (roll < 98) len = $urandom();
      else len = '0;
      // A small id pool makes ties on both remaining time and id likely.
      id = ($urandom_range(99) < 70) ? ID_W'($urandom_range(65535)) :
                                       ID_W'($urandom_range(7));
      if ($urandom_range(99) < arrive_pct) begin
        arrive(id, len, advance);
      end else begin
        complete(advance);
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/srpt_pkg.sv
sv/srpt_alu.sv
sv/srpt_table.sv
sv/srpt_job_scheduler.sv
sim/srpt_checker.sv
sim/tb_top.sv
